// ===== src/assert_macros.svh =====
// Assertion macros shared by the transcoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define BOMT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define BOMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bomt_pkg.sv =====
// Types, constants and helper functions of the byte-order-mark transcoder.
package bomt_pkg;

    // Encoding codes as reported on the result stream.
    typedef enum logic [1:0] {
        ENC_NONE    = 2'd0,
        ENC_UTF8    = 2'd1,
        ENC_UTF16LE = 2'd2,
        ENC_UTF16BE = 2'd3
    } enc_t;

    // Progress of the mark detection at the head of a file.
    typedef enum logic [1:0] {
        HDR_EMPTY = 2'd0,
        HDR_ONE   = 2'd1,
        HDR_TWO   = 2'd2,
        HDR_DONE  = 2'd3
    } hdr_t;

    // Mark bytes.
    localparam logic [7:0] BOM8_B0  = 8'hEF;
    localparam logic [7:0] BOM8_B1  = 8'hBB;
    localparam logic [7:0] BOM8_B2  = 8'hBF;
    localparam logic [7:0] BOM16_FF = 8'hFF;
    localparam logic [7:0] BOM16_FE = 8'hFE;

    // UTF-8 prefix patterns and masks.
    localparam logic [7:0] UTF8_CONT   = 8'h80;
    localparam logic [7:0] UTF8_LEAD2  = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3  = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4  = 8'hF0;
    localparam logic [7:0] UTF8_MASK4  = 8'hF8;
    localparam logic [7:0] UTF8_LOW6   = 8'h3F;
    localparam logic [15:0] UNIT_TWO_BYTES = 16'h0800;

    // Most results a single input byte can produce.
    localparam int MAX_RES = 3;

    // Results of one input byte, handed from the decoder to the output sequencer.
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [1:0]              count;
        logic                    data_valid;
        logic                    eof;
        logic                    status;
        enc_t                    enc;
    } res_bundle_t;

    // Validation state for unmarked input.
    typedef struct packed {
        logic [1:0] cont;
        logic       err;
    } chk_t;

    // One step of the lead/continuation check.
    function automatic chk_t check_byte(chk_t cur, logic [7:0] b);
        chk_t nxt;
        nxt = cur;
        if (cur.cont != 2'd0) begin
            if ((b & UTF8_LEAD2) != UTF8_CONT) begin
                nxt.err  = 1'b1;
                nxt.cont = 2'd0;
            end
            else begin
                nxt.cont = cur.cont - 2'd1;
            end
        end
        else if (b < UTF8_CONT) begin
            nxt = cur;
        end
        else if ((b & UTF8_LEAD3) == UTF8_LEAD2) begin
            nxt.cont = 2'd1;
        end
        else if ((b & UTF8_LEAD4) == UTF8_LEAD3) begin
            nxt.cont = 2'd2;
        end
        else if ((b & UTF8_MASK4) == UTF8_LEAD4) begin
            nxt.cont = 2'd3;
        end
        else begin
            nxt.err = 1'b1;
        end
        return nxt;
    endfunction

endpackage

// ===== src/bomt_decode.sv =====
// Input register, file state and the per-byte decode into a bundle of results.
module bomt_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // last_byte
    input  logic                  out_free,
    output logic                  load_valid,
    output bomt_pkg::res_bundle_t bundle
);
    import bomt_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       adv;

    hdr_t       hdr_reg, hdr_next, hdr_mid;
    enc_t       enc_reg, enc_next, enc_mid;
    logic [7:0] h0_reg, h0_next;
    logic [7:0] h1_reg, h1_next;
    logic [7:0] held_reg, held_next;
    logic       half_reg, half_next, half_mid;
    logic [1:0] cont_reg, cont_next;
    logic       err_reg, err_next;

    logic [MAX_RES-1:0][7:0] pass_b;
    logic [1:0]              pass_n;
    logic [MAX_RES-1:0][7:0] emit_b;
    logic [1:0]              emit_n;
    logic [15:0]             unit;
    chk_t                    chk_v [0:MAX_RES];
    logic                    err_final;

    // Input register: a new transaction enters while it is empty or whenever the held one moves on.
    assign adv      = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Code unit from a completed UTF-16 pair.
    assign unit = (enc_reg == ENC_UTF16LE) ? {in_byte_reg, held_reg}
                                           : {held_reg, in_byte_reg};

    // Mark detection and choice of the bytes to pass, check or encode.
    always_comb
    begin
        hdr_mid   = hdr_reg;
        enc_mid   = enc_reg;
        h0_next   = h0_reg;
        h1_next   = h1_reg;
        held_next = held_reg;
        half_mid  = half_reg;
        pass_b    = '0;
        pass_n    = 2'd0;
        emit_b    = '0;
        emit_n    = 2'd0;
        unique case (hdr_reg)
            HDR_EMPTY:
            begin
                if (in_last_reg)
                begin
                    enc_mid   = ENC_NONE;
                    hdr_mid   = HDR_DONE;
                    pass_b[0] = in_byte_reg;
                    pass_n    = 2'd1;
                end
                else
                begin
                    h0_next = in_byte_reg;
                    hdr_mid = HDR_ONE;
                end
            end
            HDR_ONE:
            begin
                if (h0_reg == BOM16_FF && in_byte_reg == BOM16_FE)
                begin
                    enc_mid = ENC_UTF16LE;
                    hdr_mid = HDR_DONE;
                end
                else if (h0_reg == BOM16_FE && in_byte_reg == BOM16_FF)
                begin
                    enc_mid = ENC_UTF16BE;
                    hdr_mid = HDR_DONE;
                end
                else if (h0_reg == BOM8_B0 && in_byte_reg == BOM8_B1 && !in_last_reg)
                begin
                    h1_next = in_byte_reg;
                    hdr_mid = HDR_TWO;
                end
                else
                begin
                    enc_mid   = ENC_NONE;
                    hdr_mid   = HDR_DONE;
                    pass_b[0] = h0_reg;
                    pass_b[1] = in_byte_reg;
                    pass_n    = 2'd2;
                end
            end
            HDR_TWO:
            begin
                hdr_mid = HDR_DONE;
                if (in_byte_reg == BOM8_B2)
                begin
                    enc_mid = ENC_UTF8;
                end
                else
                begin
                    enc_mid   = ENC_NONE;
                    pass_b[0] = h0_reg;
                    pass_b[1] = h1_reg;
                    pass_b[2] = in_byte_reg;
                    pass_n    = 2'd3;
                end
            end
            HDR_DONE:
            begin
                unique case (enc_reg)
                    ENC_NONE:
                    begin
                        pass_b[0] = in_byte_reg;
                        pass_n    = 2'd1;
                    end
                    ENC_UTF8:
                    begin
                        emit_b[0] = in_byte_reg;
                        emit_n    = 2'd1;
                    end
                    default:
                    begin
                        if (!half_reg)
                        begin
                            held_next = in_byte_reg;
                            half_mid  = 1'b1;
                        end
                        else
                        begin
                            half_mid = 1'b0;
                            if (unit < {8'h00, UTF8_CONT})
                            begin
                                emit_b[0] = unit[7:0];
                                emit_n    = 2'd1;
                            end
                            else if (unit < UNIT_TWO_BYTES)
                            begin
                                emit_b[0] = UTF8_LEAD2 | {3'b000, unit[10:6]};
                                emit_b[1] = UTF8_CONT | {2'b00, unit[5:0]};
                                emit_n    = 2'd2;
                            end
                            else
                            begin
                                emit_b[0] = UTF8_LEAD3 | {4'b0000, unit[15:12]};
                                emit_b[1] = UTF8_CONT | (unit[13:6] & UTF8_LOW6);
                                emit_b[2] = UTF8_CONT | {2'b00, unit[5:0]};
                                emit_n    = 2'd3;
                            end
                        end
                    end
                endcase
            end
        endcase
    end

    // Validation chain over the bytes that pass unchecked data.
    always_comb
    begin
        chk_v[0] = '{cont: cont_reg, err: err_reg};
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (i < int'(pass_n))
            begin
                chk_v[i+1] = check_byte(chk_v[i], pass_b[i]);
            end
            else
            begin
                chk_v[i+1] = chk_v[i];
            end
        end
    end

    // Result bundle, end-of-file status and the state for the next byte.
    always_comb
    begin
        err_final = chk_v[MAX_RES].err;
        if (in_last_reg && enc_mid == ENC_NONE && chk_v[MAX_RES].cont != 2'd0)
        begin
            err_final = 1'b1;
        end

        bundle.enc        = enc_mid;
        bundle.eof        = in_last_reg;
        bundle.status     = in_last_reg && (enc_mid == ENC_NONE) && err_final;
        bundle.data_valid = 1'b1;
        if (pass_n != 2'd0)
        begin
            bundle.bytes = pass_b;
            bundle.count = pass_n;
        end
        else
        begin
            bundle.bytes = emit_b;
            bundle.count = emit_n;
        end
        if (in_last_reg && bundle.count == 2'd0)
        begin
            bundle.bytes      = '0;
            bundle.count      = 2'd1;
            bundle.data_valid = 1'b0;
        end

        // The final byte of a file returns the state to its reset values.
        if (in_last_reg)
        begin
            hdr_next  = HDR_EMPTY;
            enc_next  = ENC_NONE;
            half_next = 1'b0;
            cont_next = 2'd0;
            err_next  = 1'b0;
        end
        else
        begin
            hdr_next  = hdr_mid;
            enc_next  = enc_mid;
            half_next = half_mid;
            cont_next = chk_v[MAX_RES].cont;
            err_next  = err_final;
        end
    end

    assign load_valid = in_valid_reg && (bundle.count != 2'd0);

    // File state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg  <= HDR_EMPTY;
            enc_reg  <= ENC_NONE;
            half_reg <= 1'b0;
            cont_reg <= 2'd0;
            err_reg  <= 1'b0;
        end
        else if (adv)
        begin
            hdr_reg  <= hdr_next;
            enc_reg  <= enc_next;
            half_reg <= half_next;
            cont_reg <= cont_next;
            err_reg  <= err_next;
        end
    end

    // Held header bytes and the first half of a UTF-16 pair.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h0_reg   <= h0_next;
            h1_reg   <= h1_next;
            held_reg <= held_next;
        end
    end

endmodule

// ===== src/bomt_out_seq.sv =====
// Result register that hands out the results of one byte, one transaction per cycle while m_tready is high.
module bomt_out_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    input  bomt_pkg::res_bundle_t bundle,
    output logic                  out_free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic [4:0]            m_tuser,   // [0] byte_valid, [1] run_last, [2] status,
                                             // [4:3] encoding
    output logic                  m_tlast    // end_of_file
);
    import bomt_pkg::*;

    res_bundle_t bundle_reg;
    logic        busy_reg;
    logic [1:0]  idx_reg;
    logic        last_one;
    logic        load;

    assign last_one = (idx_reg == (bundle_reg.count - 2'd1));
    assign out_free = !busy_reg || (last_one && m_tready);
    assign load     = load_valid && out_free;

    // Control: busy while results remain, index of the next one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (busy_reg && m_tready)
        begin
            if (last_one)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bundle_reg <= bundle;
        end
    end

    // Output fields of the current result.
    assign m_tvalid = busy_reg;
    assign m_tdata  = bundle_reg.data_valid ? bundle_reg.bytes[idx_reg] : 8'h00;
    assign m_tlast  = last_one && bundle_reg.eof;
    assign m_tuser  = {bundle_reg.enc,
                       last_one && bundle_reg.eof && bundle_reg.status,
                       last_one,
                       bundle_reg.data_valid};

endmodule

// ===== src/bom_detect_text_transcoder.sv =====
// Top level of the byte-order-mark detecting UTF-16 to UTF-8 transcoder.
//
//   Channel  Direction  tdata         tlast        tuser
//   s_axis   in         data_byte     last_byte    -
//   m_axis   out        out_byte      end_of_file  byte_valid, run_last, status, encoding
//
// An input byte is registered, decoded into up to three results and loaded into the
// result register once that register is free. One result leaves per cycle while
// m_tready is high, so a byte that yields several results, such as a UTF-16 pair or
// the held bytes flushed when a mark is ruled out, holds the output until its last leaves.
// Reset clears the file state; the next file starts after the last_byte transaction.
// While results wait on m_tready the input register takes one more transaction and then
// holds s_tready low until the last result of the current byte leaves.
`include "assert_macros.svh"

module bom_detect_text_transcoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [4:0] m_tuser,   // [0] byte_valid, [1] run_last, [2] status, [4:3] encoding
    output logic       m_tlast    // end_of_file
);
    import bomt_pkg::*;

    res_bundle_t bundle;
    logic        load_valid;
    logic        out_free;

    // Input register and decode.
    bomt_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .out_free  (out_free),
        .load_valid(load_valid),
        .bundle    (bundle)
    );

    // Result register and sequencing.
    bomt_out_seq u_out_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_valid(load_valid),
        .bundle    (bundle),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // An error status only appears on the end-of-file transaction.
    `BOMT_ASSERT_IMPL(a_status_at_eof, m_tvalid && m_tuser[2], m_tlast, "status before eof")
    // End of file closes the run of its input byte.
    `BOMT_ASSERT_IMPL(a_eof_run_last, m_tvalid && m_tlast, m_tuser[1], "eof not at run end")
    // A status-only transaction is only ever the end of a file.
    `BOMT_ASSERT_IMPL(a_empty_is_eof, m_tvalid && !m_tuser[0], m_tlast, "status-only in file")
    // A run with results still to come keeps the output busy.
    `BOMT_ASSERT_NEXT(a_run_continues, m_tvalid && m_tready && !m_tuser[1], m_tvalid, "run cut short")

endmodule
